[rtl/zsew_pkg.sv]
`timescale 1ns / 1ps

package zsew_pkg;

  localparam int POS_W       = 32;
  localparam int LEN_W       = 32;
  localparam int NHP_W       = LEN_W + 1;
  localparam int OFF_W       = LEN_W + 2;
  localparam int END_W       = LEN_W + 1;
  localparam int HBC_W       = 5;
  localparam int DATA_ALIGN  = 64;
  localparam int ALIGN_BITS  = $clog2(DATA_ALIGN);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam logic [LEN_W-1:0] MIN_ARCHIVE = LEN_W'((11 * 8) + 30);
  localparam logic [OFF_W-1:0] HEADER_LEN  = OFF_W'(30);
  localparam logic [7:0]       SIG_BYTE2   = 8'h03;
  localparam logic [7:0]       SIG_BYTE3   = 8'h04;

  localparam logic [HBC_W-1:0] HB_BASE     = 5'd1;
  localparam logic [HBC_W-1:0] HB_SIG2     = 5'd2;
  localparam logic [HBC_W-1:0] HB_SIG3     = 5'd3;
  localparam logic [HBC_W-1:0] HB_METH_LO  = 5'd8;
  localparam logic [HBC_W-1:0] HB_METH_HI  = 5'd9;
  localparam logic [HBC_W-1:0] HB_SIZE_0   = 5'd22;
  localparam logic [HBC_W-1:0] HB_SIZE_1   = 5'd23;
  localparam logic [HBC_W-1:0] HB_SIZE_2   = 5'd24;
  localparam logic [HBC_W-1:0] HB_SIZE_3   = 5'd25;
  localparam logic [HBC_W-1:0] HB_NAME_LO  = 5'd26;
  localparam logic [HBC_W-1:0] HB_NAME_HI  = 5'd27;
  localparam logic [HBC_W-1:0] HB_EXTRA_LO = 5'd28;
  localparam logic [HBC_W-1:0] HB_EXTRA_HI = 5'd29;

  typedef enum logic [2:0] {
    ST_ENTRY      = 3'd0,
    ST_END_OK     = 3'd1,
    ST_SHORT      = 3'd2,
    ST_NAME       = 3'd3,
    ST_EXTRA      = 3'd4,
    ST_ALIGN      = 3'd5,
    ST_COMPRESSED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_DONE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_SKIP   = 3'b100
  } phase_t;

  typedef enum logic {
    CMD_FINISH = 1'b0,
    CMD_HEADER = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic             restart;
    cmd_kind_t        kind;
    status_t          status;
    logic             name_over;
    logic             method_nz;
    logic [15:0]      extra;
    logic [OFF_W-1:0] data_off;
    logic [OFF_W-1:0] data_end;
  } cmd_t;

endpackage

[rtl/zsew_front.sv]
`timescale 1ns / 1ps

module zsew_front
  import zsew_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       byte_value,
  input  logic             first_byte,
  input  logic [LEN_W-1:0] total_length,
  output logic             push,
  output cmd_t             cmd
);

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [NHP_W-1:0]   nhp_r, nhp_nxt;
  logic [HBC_W-1:0]   hbc_r, hbc_nxt;
  logic               pend_r, pend_nxt;
  logic [OFF_W-1:0]   base_r, base_nxt;
  logic [OFF_W-1:0]   off1_r, off1_nxt;
  logic [OFF_W-1:0]   off1s_r, off1s_nxt;
  logic [31:0]        size_r, size_nxt;
  logic [7:0]         name_lo_r, name_lo_nxt;
  logic [7:0]         extra_lo_r, extra_lo_nxt;
  logic [7:0]         meth_lo_r, meth_lo_nxt;
  logic               meth_nz_r, meth_nz_nxt;
  logic               name_over_r, name_over_nxt;
  logic               hdr_go;
  logic [HBC_W-1:0]   k;
  logic [15:0]        extra_full;
  logic [OFF_W-1:0]   total_ext;

  assign extra_full = {byte_value, extra_lo_r};
  assign total_ext  = {{(OFF_W-LEN_W){1'b0}}, total_length};

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    nhp_nxt       = nhp_r;
    hbc_nxt       = hbc_r;
    pend_nxt      = pend_r;
    base_nxt      = base_r;
    off1_nxt      = off1_r;
    off1s_nxt     = off1s_r;
    size_nxt      = size_r;
    name_lo_nxt   = name_lo_r;
    extra_lo_nxt  = extra_lo_r;
    meth_lo_nxt   = meth_lo_r;
    meth_nz_nxt   = meth_nz_r;
    name_over_nxt = name_over_r;
    hdr_go        = 1'b0;
    k             = hbc_r;
    push          = 1'b0;
    cmd           = '0;
    cmd.kind      = CMD_FINISH;
    cmd.status    = ST_END_OK;

    if (acc) begin
      if (first_byte) begin
        pos_nxt  = '0;
        nhp_nxt  = '0;
        pend_nxt = 1'b1;
        if (total_length < MIN_ARCHIVE) begin
          push       = 1'b1;
          cmd.status = ST_SHORT;
          phase_nxt  = PH_DONE;
        end else begin
          phase_nxt = PH_HEADER;
          hdr_go    = 1'b1;
          k         = '0;
        end
      end else if (phase_r != PH_DONE) begin
        pos_nxt = pos_r + POS_W'(1);
        if (phase_r == PH_SKIP) begin
          if (({1'b0, nhp_r} + HEADER_LEN) >= total_ext) begin
            push       = 1'b1;
            cmd.status = ST_END_OK;
            phase_nxt  = PH_DONE;
          end else if (pos_nxt == POS_W'(nhp_r)) begin
            phase_nxt = PH_HEADER;
            hdr_go    = 1'b1;
            k         = '0;
          end
        end else begin
          hdr_go = 1'b1;
        end
      end
    end

    if (hdr_go) begin
      hbc_nxt = k + HBC_W'(1);
      unique case (k)
        HB_BASE:     base_nxt = {1'b0, nhp_r} + HEADER_LEN;
        HB_SIG2: begin
          if (byte_value != SIG_BYTE2) begin
            push       = 1'b1;
            cmd.status = ST_END_OK;
            phase_nxt  = PH_DONE;
          end
        end
        HB_SIG3: begin
          if (byte_value != SIG_BYTE3) begin
            push       = 1'b1;
            cmd.status = ST_END_OK;
            phase_nxt  = PH_DONE;
          end
        end
        HB_METH_LO:  meth_lo_nxt = byte_value;
        HB_METH_HI:  meth_nz_nxt = (byte_value != 8'd0) || (meth_lo_r != 8'd0);
        HB_SIZE_0,
        HB_SIZE_1,
        HB_SIZE_2,
        HB_SIZE_3:   size_nxt = {byte_value, size_r[31:8]};
        HB_NAME_LO:  name_lo_nxt = byte_value;
        HB_NAME_HI:  off1_nxt = base_r + {{(OFF_W-16){1'b0}}, byte_value, name_lo_r};
        HB_EXTRA_LO: begin
          extra_lo_nxt  = byte_value;
          name_over_nxt = off1_r > total_ext;
          off1s_nxt     = off1_r + {{(OFF_W-32){1'b0}}, size_r};
        end
        HB_EXTRA_HI: begin
          push          = 1'b1;
          cmd.kind      = CMD_HEADER;
          cmd.status    = ST_ENTRY;
          cmd.name_over = name_over_r;
          cmd.method_nz = meth_nz_r;
          cmd.extra     = extra_full;
          cmd.data_off  = off1_r + {{(OFF_W-16){1'b0}}, extra_full};
          cmd.data_end  = off1s_r + {{(OFF_W-16){1'b0}}, extra_full};
          nhp_nxt       = cmd.data_end[NHP_W-1:0];
          phase_nxt     = PH_SKIP;
        end
        default: ;
      endcase
    end

    if (push) begin
      cmd.restart = pend_nxt;
      pend_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      pos_r   <= '0;
      nhp_r   <= '0;
      hbc_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      nhp_r   <= nhp_nxt;
      hbc_r   <= hbc_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    off1_r      <= off1_nxt;
    off1s_r     <= off1s_nxt;
    size_r      <= size_nxt;
    name_lo_r   <= name_lo_nxt;
    extra_lo_r  <= extra_lo_nxt;
    meth_lo_r   <= meth_lo_nxt;
    meth_nz_r   <= meth_nz_nxt;
    name_over_r <= name_over_nxt;
  end

  a_short_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    acc && first_byte && (total_length < MIN_ARCHIVE) |=> phase_r == PH_DONE)
    else $error("short archive did not end the walk");

endmodule

[rtl/zsew_cmd_fifo.sv]
`timescale 1ns / 1ps

module zsew_cmd_fifo
  import zsew_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full       = count_r == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (FIFO_PTR_W+1)'(do_push) - (FIFO_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into a full queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

[rtl/zsew_back.sv]
`timescale 1ns / 1ps

module zsew_back
  import zsew_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] total_length,
  input  logic             head_valid,
  input  cmd_t             head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [LEN_W-1:0] out_entry_begin,
  output logic [END_W-1:0] out_entry_end
);

  logic             valid_r, valid_nxt;
  logic             dead_r, dead_nxt;
  status_t          status_r, status_nxt;
  logic [LEN_W-1:0] begin_r, begin_nxt;
  logic [END_W-1:0] end_r, end_nxt;
  logic             live;
  status_t          st;
  logic [OFF_W-1:0] total_ext;

  assign total_ext = {{(OFF_W-LEN_W){1'b0}}, total_length};
  assign pop       = head_valid && (!valid_r || out_ready);
  assign live      = head_cmd.restart || !dead_r;

  always_comb begin
    if (head_cmd.kind == CMD_FINISH) begin
      st = head_cmd.status;
    end else if (head_cmd.name_over) begin
      st = ST_NAME;
    end else if ((head_cmd.extra != 16'd0) && (head_cmd.data_off > total_ext)) begin
      st = ST_EXTRA;
    end else if (head_cmd.data_off[ALIGN_BITS-1:0] != '0) begin
      st = ST_ALIGN;
    end else if (head_cmd.method_nz) begin
      st = ST_COMPRESSED;
    end else begin
      st = ST_ENTRY;
    end
  end

  always_comb begin
    valid_nxt  = valid_r && !out_ready;
    dead_nxt   = dead_r;
    status_nxt = status_r;
    begin_nxt  = begin_r;
    end_nxt    = end_r;
    if (pop && live) begin
      valid_nxt  = 1'b1;
      status_nxt = st;
      dead_nxt   = st != ST_ENTRY;
      if (st == ST_ENTRY) begin
        begin_nxt = head_cmd.data_off[LEN_W-1:0];
        end_nxt   = head_cmd.data_end[END_W-1:0];
      end else begin
        begin_nxt = '0;
        end_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dead_r  <= 1'b1;
    end else begin
      valid_r <= valid_nxt;
      dead_r  <= dead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    begin_r  <= begin_nxt;
    end_r    <= end_nxt;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_entry_begin = begin_r;
  assign out_entry_end   = end_r;

  a_entry_end_not_below_begin: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (status_r == ST_ENTRY) |-> end_r >= {1'b0, begin_r})
    else $error("entry ends before it begins");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (status_r != ST_ENTRY) |-> (begin_r == '0) && (end_r == '0))
    else $error("offsets set on a result that is not an entry");

  a_dead_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
    pop && live && (st != ST_ENTRY) |=> dead_r)
    else $error("walk not closed after a final result");

endmodule

[rtl/zip_stored_entry_walker.sv]
`timescale 1ns / 1ps

// Walks the local file headers of a ZIP archive streamed in one byte per beat.
// Write the archive length through cfg_we/cfg_wdata before the first beat, then
// send the bytes from offset zero with in_first_byte set on the first one.
// For each local header one result beat is produced: status 0 with the data
// begin and end offsets of a stored entry, or a final status (walk ended,
// archive too short, name or extra overrun, misaligned data, compressed)
// with zero offsets, after which bytes are ignored until the next first byte.
// Input beats are taken at one per cycle while in_ready is high; each byte is
// handled by the header parser in the cycle it is accepted, and any result it
// causes passes through the command queue and then the output register.
// Parser and checker are coupled by a four-deep command queue and an output
// register, so in_ready stays high while the receiver stalls until one result
// is held at the output and four more wait in the queue; then it drops until
// out_ready takes one.
// After reset the archive length is zero and the walk is finished, so bytes
// are ignored until a beat with in_first_byte arrives.
module zip_stored_entry_walker
  import zsew_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte_value,
  input  logic             in_first_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [LEN_W-1:0] out_entry_begin,
  output logic [END_W-1:0] out_entry_end
);

  logic [LEN_W-1:0] total_length_r;
  logic             acc;
  logic             push;
  cmd_t             push_cmd;
  logic             full;
  logic             pop;
  logic             head_valid;
  cmd_t             head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r <= '0;
    end else if (cfg_we) begin
      total_length_r <= cfg_wdata;
    end
  end

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  zsew_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .byte_value   (in_byte_value),
    .first_byte   (in_first_byte),
    .total_length (total_length_r),
    .push         (push),
    .cmd          (push_cmd)
  );

  zsew_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  zsew_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .total_length    (total_length_r),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_begin (out_entry_begin),
    .out_entry_end   (out_entry_end)
  );

endmodule

[tb/zsew_walk_checker.sv]
`timescale 1ns / 1ps

module zsew_walk_checker
  import zsew_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_byte_value,
  input  logic             in_first_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [2:0]       out_status,
  input  logic [LEN_W-1:0] out_entry_begin,
  input  logic [END_W-1:0] out_entry_end,
  output int               fail_count,
  output int               open_results
);

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] entry_begin;
    logic [END_W-1:0] entry_end;
  } walk_result_t;

  walk_result_t     expected_results[$];
  int               mismatches;

  logic [LEN_W-1:0] total_len;
  logic [POS_W-1:0] arc_pos;
  phase_t           walk_phase;
  logic [HBC_W-1:0] hdr_count;
  logic [15:0]      method_word;
  logic [15:0]      name_bytes;
  logic [15:0]      extra_len;
  logic [31:0]      entry_size;
  logic [33:0]      next_hdr;

  initial begin
    fail_count   = 0;
    open_results = 0;
    mismatches   = 0;
  end

  function automatic void clear_walk();
    total_len   = '0;
    arc_pos     = '0;
    walk_phase  = PH_DONE;
    hdr_count   = '0;
    method_word = '0;
    name_bytes  = '0;
    extra_len   = '0;
    entry_size  = '0;
    next_hdr    = '0;
  endfunction

  function automatic void close_walk(status_t st);
    walk_phase = PH_DONE;
    expected_results.insert(expected_results.size(), '{st, '0, '0});
  endfunction

  function automatic void predict_header_walk(logic [7:0] b, logic fb);
    logic [63:0]      off;
    logic [HBC_W-1:0] k;
    if (fb) begin
      arc_pos   = '0;
      next_hdr  = '0;
      hdr_count = '0;
      if (total_len < MIN_ARCHIVE) begin
        close_walk(ST_SHORT);
        return;
      end
      walk_phase = PH_HEADER;
    end else begin
      if (walk_phase != PH_HEADER && walk_phase != PH_SKIP) return;
      arc_pos = arc_pos + 1'b1;
    end

    if (walk_phase == PH_SKIP) begin
      if (64'(next_hdr) + 64'(HEADER_LEN) >= 64'(total_len)) begin
        close_walk(ST_END_OK);
        return;
      end
      if (arc_pos != next_hdr[POS_W-1:0]) return;
      walk_phase = PH_HEADER;
      hdr_count  = '0;
    end

    k = hdr_count;
    if (k == '0) begin
      method_word = '0;
      name_bytes  = '0;
      extra_len   = '0;
      entry_size  = '0;
    end
    hdr_count = k + 1'b1;

    case (k)
      HB_SIG2:     if (b != SIG_BYTE2) close_walk(ST_END_OK);
      HB_SIG3:     if (b != SIG_BYTE3) close_walk(ST_END_OK);
      HB_METH_LO:  method_word[7:0]  = b;
      HB_METH_HI:  method_word[15:8] = b;
      HB_SIZE_0:   entry_size[7:0]   = b;
      HB_SIZE_1:   entry_size[15:8]  = b;
      HB_SIZE_2:   entry_size[23:16] = b;
      HB_SIZE_3:   entry_size[31:24] = b;
      HB_NAME_LO:  name_bytes[7:0]   = b;
      HB_NAME_HI:  name_bytes[15:8]  = b;
      HB_EXTRA_LO: extra_len[7:0]    = b;
      HB_EXTRA_HI: begin
        extra_len[15:8] = b;
        off = 64'(next_hdr) + 64'(HEADER_LEN);
        if (off + 64'(name_bytes) > 64'(total_len)) begin
          close_walk(ST_NAME);
          return;
        end
        off = off + 64'(name_bytes);
        if (extra_len != '0 && off + 64'(extra_len) > 64'(total_len)) begin
          close_walk(ST_EXTRA);
          return;
        end
        off = off + 64'(extra_len);
        if (off % DATA_ALIGN != 0) begin
          close_walk(ST_ALIGN);
          return;
        end
        if (method_word != '0) begin
          close_walk(ST_COMPRESSED);
          return;
        end
        next_hdr   = 34'(off + 64'(entry_size));
        walk_phase = PH_SKIP;
        expected_results.insert(expected_results.size(),
                                '{ST_ENTRY, off[LEN_W-1:0],
                                  END_W'(off + 64'(entry_size))});
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    walk_result_t exp_r;
    if (!rst_n) begin
      clear_walk();
      expected_results.delete();
    end else begin
      if (cfg_we) total_len = cfg_wdata;
      if (in_valid && in_ready) predict_header_walk(in_byte_value, in_first_byte);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d begin %0d end %0d",
                   $time, out_status, out_entry_begin, out_entry_end);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_status !== exp_r.status) begin
            $display("%0t: status expected %0d, got %0d", $time, exp_r.status, out_status);
            mismatches++;
          end
          if (out_entry_begin !== exp_r.entry_begin) begin
            $display("%0t: entry_begin expected %0d, got %0d",
                     $time, exp_r.entry_begin, out_entry_begin);
            mismatches++;
          end
          if (out_entry_end !== exp_r.entry_end) begin
            $display("%0t: entry_end expected %0d, got %0d",
                     $time, exp_r.entry_end, out_entry_end);
            mismatches++;
          end
        end
      end
    end
    fail_count   <= mismatches;
    open_results <= expected_results.size();
  end

endmodule

[tb/zip_stored_entry_walker_tb.sv]
`timescale 1ns / 1ps

module zip_stored_entry_walker_tb
  import zsew_pkg::*;
();

  localparam int STALL_LIMIT = 2000;

  typedef enum int {
    HK_GOOD       = 0,
    HK_NAME_OVER  = 1,
    HK_EXTRA_OVER = 2,
    HK_MISALIGN   = 3,
    HK_COMPRESSED = 4,
    HK_BAD_SIG2   = 5,
    HK_BAD_SIG3   = 6,
    HK_NOISE      = 7
  } hdr_kind_t;

  logic             clk;
  logic             rst_n           = 1'b0;
  logic             cfg_we          = 1'b0;
  logic [LEN_W-1:0] cfg_wdata       = '0;
  logic             in_valid        = 1'b0;
  logic             in_ready;
  logic [7:0]       in_byte_value   = '0;
  logic             in_first_byte   = 1'b0;
  logic             out_valid;
  logic             out_ready       = 1'b0;
  logic [2:0]       out_status;
  logic [LEN_W-1:0] out_entry_begin;
  logic [END_W-1:0] out_entry_end;

  int               fail_count;
  int               open_results;

  logic [7:0]       arc_q[$];
  int               bytes_sent   = 0;
  int               in_idle_pct  = 10;
  int               out_idle_pct = 10;
  int               stall_cycles = 0;
  logic [LEN_W-1:0] cur_total    = '0;

  zip_stored_entry_walker u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_value   (in_byte_value),
    .in_first_byte   (in_first_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_begin (out_entry_begin),
    .out_entry_end   (out_entry_end)
  );

  zsew_walk_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("zip_stored_entry_walker verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic fb);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_first_byte <= fb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_total(input logic [LEN_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_total = v;
  endtask

  task automatic push_junk(input int n);
    repeat (n) arc_q.insert(arc_q.size(), 8'($urandom_range(0, 255)));
  endtask

  function automatic hdr_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return HK_GOOD;
    return hdr_kind_t'(1 + r % 7);
  endfunction

  // Builds one archive into arc_q, laid out against the planned length.
  task automatic build_archive(input logic [63:0] plan, input int entries,
                               input hdr_kind_t first_kind, input bit max_size);
    logic [63:0] pos;
    logic [63:0] start;
    logic [63:0] off;
    logic [63:0] nxt;
    logic [15:0] name_bytes;
    logic [15:0] extra_len;
    logic [15:0] method;
    logic [31:0] size;
    logic [7:0]  hdr[30];
    hdr_kind_t   kind;
    pos = '0;
    for (int e = 0; e < entries; e++) begin
      if (pos + 30 >= plan) begin
        push_junk($urandom_range(0, 3));
        return;
      end
      kind       = (e == 0) ? first_kind : pick_kind();
      start      = pos + 30;
      name_bytes = 16'($urandom_range(0, 40));
      extra_len  = 16'((64 - (start + name_bytes) % 64) % 64 + 64 * $urandom_range(0, 1));
      method     = '0;
      size       = $urandom_range(0, 60);
      if ((e == 0 && max_size) || $urandom_range(0, 24) == 0)
        size = max_size ? 32'hFFFF_FFFF : $urandom();
      case (kind)
        HK_NAME_OVER:
          name_bytes = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                   : 16'(plan - start + $urandom_range(0, 3));
        HK_EXTRA_OVER: begin
          name_bytes = 16'($urandom_range(0, 32'(plan - start)));
          extra_len  = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                       : 16'(plan - start - name_bytes + $urandom_range(0, 3));
        end
        HK_MISALIGN:   extra_len = extra_len + 16'($urandom_range(1, 63));
        HK_COMPRESSED: method = 16'($urandom_range(1, 16'hFFFF));
        default: ;
      endcase
      foreach (hdr[i]) hdr[i] = 8'($urandom_range(0, 255));
      if (kind != HK_NOISE) begin
        hdr[HB_SIG2] = SIG_BYTE2;
        hdr[HB_SIG3] = SIG_BYTE3;
        {hdr[HB_METH_HI], hdr[HB_METH_LO]}  = method;
        {hdr[HB_SIZE_3], hdr[HB_SIZE_2], hdr[HB_SIZE_1], hdr[HB_SIZE_0]} = size;
        {hdr[HB_NAME_HI], hdr[HB_NAME_LO]}  = name_bytes;
        {hdr[HB_EXTRA_HI], hdr[HB_EXTRA_LO]} = extra_len;
      end
      if (kind == HK_BAD_SIG2) hdr[HB_SIG2] = SIG_BYTE2 ^ 8'($urandom_range(1, 255));
      if (kind == HK_BAD_SIG3) hdr[HB_SIG3] = SIG_BYTE3 ^ 8'($urandom_range(1, 255));
      foreach (hdr[i]) arc_q.insert(arc_q.size(), hdr[i]);
      off = start + name_bytes + extra_len;
      nxt = off + size;
      if (kind != HK_GOOD || nxt + 30 >= plan) begin
        push_junk($urandom_range(0, 4));
        return;
      end
      push_junk(int'(nxt - start));
      pos = nxt;
    end
    push_junk($urandom_range(0, 3));
  endtask

  task automatic send_archive();
    foreach (arc_q[i]) send_beat(arc_q[i], i == 0);
    arc_q.delete();
  endtask

  initial begin
    logic [LEN_W-1:0] tot;
    logic [63:0]      plan;
    int               r;
    int               arc_num;
    arc_num = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Beats before any first byte are ignored; a first byte then finds the
    // archive length still at zero.
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h50, 1'b1);
    send_beat(8'hA5, 1'b0);

    write_total(32'd117);
    build_archive(200, 1, HK_GOOD, 1'b0);
    send_archive();

    write_total(32'd118);
    build_archive(118, 2, HK_GOOD, 1'b0);
    send_archive();

    for (int k = HK_GOOD; k <= HK_NOISE; k++) begin
      write_total(32'd300 + 32'(k));
      build_archive(300 + k, 3, hdr_kind_t'(k), 1'b0);
      send_archive();
    end

    write_total(32'd400);
    build_archive(400, 2, HK_GOOD, 1'b1);
    send_archive();

    write_total(32'hFFFF_FFFF);
    build_archive(400, 4, HK_GOOD, 1'b1);
    send_archive();

    while (bytes_sent < 2000) begin
      in_idle_pct  = (arc_num >= 5 && arc_num < 10) ? 0 : 10;
      out_idle_pct = in_idle_pct;
      plan = ($urandom_range(0, 3) == 0) ? $urandom_range(118, 200) : $urandom_range(118, 600);
      build_archive(plan, $urandom_range(1, 8), pick_kind(), 1'b0);
      r = $urandom_range(0, 99);
      if (r < 80)      tot = 32'(plan);
      else if (r < 85) tot = 32'hFFFF_FFFF;
      else if (r < 90) tot = $urandom_range(0, 117);
      else if (r < 95) tot = 32'(plan) + $urandom_range(1, 64);
      else             tot = $urandom();
      if (tot != cur_total || $urandom_range(0, 3) == 0) write_total(tot);
      if ($urandom_range(0, 6) == 0) arc_q = arc_q[0:$urandom_range(0, arc_q.size() - 1)];
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 40))
          send_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
      end
      send_archive();
      arc_num++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("zip_stored_entry_walker verification clean");
    end else begin
      $display("zip_stored_entry_walker verification failed");
    end
    $finish;
  end

endmodule
